[sv/ata_seq_pkg.sv]
// Shared types, codes and result-beat decoding for the ATA PIO LBA28 sequencer.
`default_nettype none

package ata_seq_pkg;

    localparam logic [20:0] POLL_LIMIT   = 21'd2000000;
    localparam int          SECTOR_WORDS = 256;

    localparam logic [1:0] KIND_REQUEST = 2'd0;
    localparam logic [1:0] KIND_REPLY   = 2'd1;
    localparam logic [1:0] KIND_WDATA   = 2'd2;

    localparam logic [1:0] OP_IDENTIFY = 2'd0;
    localparam logic [1:0] OP_READ     = 2'd1;
    localparam logic [1:0] OP_WRITE    = 2'd2;
    localparam logic [1:0] OP_INVALID  = 2'd3;

    localparam logic [9:0] PORT_DATA    = 10'h1F0;
    localparam logic [9:0] PORT_FEATURE = 10'h1F1;
    localparam logic [9:0] PORT_COUNT   = 10'h1F2;
    localparam logic [9:0] PORT_LBA_LO  = 10'h1F3;
    localparam logic [9:0] PORT_LBA_MID = 10'h1F4;
    localparam logic [9:0] PORT_LBA_HI  = 10'h1F5;
    localparam logic [9:0] PORT_DRIVE   = 10'h1F6;
    localparam logic [9:0] PORT_STATUS  = 10'h1F7;

    localparam logic [7:0] DRV_SELECT       = 8'hA0;
    localparam logic [7:0] DRV_LBA          = 8'hE0;
    localparam logic [7:0] OPC_READ_SECT    = 8'h20;
    localparam logic [7:0] OPC_WRITE_SECT   = 8'h30;
    localparam logic [7:0] OPC_CACHE_FLUSH  = 8'hE7;
    localparam logic [7:0] OPC_IDENTIFY_DEV = 8'hEC;

    localparam int ST_BSY = 7;
    localparam int ST_DF  = 5;
    localparam int ST_DRQ = 3;
    localparam int ST_ERR = 0;

    localparam logic [8:0] ID_WORD_CAP_LO = 9'd60;
    localparam logic [8:0] ID_WORD_CAP_HI = 9'd61;

    typedef enum logic [3:0] {
        PH_IDLE, PH_PRE_BSY, PH_DELAY_A, PH_DELAY_B, PH_CHECK1, PH_CHECK2,
        PH_BSY, PH_DRQ, PH_RDATA, PH_WDATA, PH_FLUSH
    } phase_t;

    typedef enum logic [3:0] {
        SEQ_NONE, SEQ_FINISH, SEQ_RD_STATUS, SEQ_ID_START, SEQ_TASKFILE,
        SEQ_RD_DATA, SEQ_DATA_RD, SEQ_DATA_DONE, SEQ_WR_WORD, SEQ_WR_LAST
    } seq_t;

    typedef struct packed {
        seq_t        seq;
        logic        ok;
        logic [27:0] lba;
        logic        count;
        logic [7:0]  cmd;
        logic [15:0] value;
        logic [31:0] sector_count;
        logic        present;
    } desc_t;

    typedef struct packed {
        logic        access_valid;
        logic        access_write;
        logic [9:0]  access_port;
        logic        access_wide;
        logic [15:0] access_value;
        logic        data_valid;
        logic [15:0] data_word;
        logic        done_res;
        logic        ok;
        logic [31:0] sector_count;
        logic        present;
    } beat_t;

    function automatic logic [3:0] seq_len(seq_t s);
        logic [3:0] n;
        unique case (s)
            SEQ_FINISH, SEQ_RD_STATUS, SEQ_RD_DATA, SEQ_WR_WORD: n = 4'd1;
            SEQ_ID_START, SEQ_DATA_RD, SEQ_DATA_DONE:            n = 4'd2;
            SEQ_WR_LAST:                                         n = 4'd3;
            SEQ_TASKFILE:                                        n = 4'd8;
            default:                                             n = 4'd0;
        endcase
        return n;
    endfunction

    function automatic beat_t make_beat(desc_t d, logic [2:0] idx);
        beat_t      b;
        logic [9:0] port;
        logic [7:0] val;
        logic       rd;
        b              = '0;
        port           = PORT_STATUS;
        val            = 8'h00;
        rd             = 1'b0;
        b.sector_count = d.sector_count;
        b.present      = d.present;
        unique case (d.seq)
            SEQ_FINISH:
            begin
                b.done_res = 1'b1;
                b.ok       = d.ok;
            end
            SEQ_RD_STATUS:
            begin
                b.access_valid = 1'b1;
                b.access_port  = PORT_STATUS;
            end
            SEQ_ID_START:
            begin
                b.access_valid = 1'b1;
                b.access_port  = (idx == 3'd0) ? PORT_DRIVE : PORT_STATUS;
                b.access_write = (idx == 3'd0);
                b.access_value = (idx == 3'd0) ? {8'h00, DRV_SELECT} : 16'h0000;
            end
            SEQ_TASKFILE:
            begin
                case (idx)
                    3'd0:
                    begin
                        port = PORT_DRIVE;
                        val  = DRV_LBA | {4'h0, d.lba[27:24]};
                    end
                    3'd1: port = PORT_FEATURE;
                    3'd2:
                    begin
                        port = PORT_COUNT;
                        val  = {7'd0, d.count};
                    end
                    3'd3:
                    begin
                        port = PORT_LBA_LO;
                        val  = d.lba[7:0];
                    end
                    3'd4:
                    begin
                        port = PORT_LBA_MID;
                        val  = d.lba[15:8];
                    end
                    3'd5:
                    begin
                        port = PORT_LBA_HI;
                        val  = d.lba[23:16];
                    end
                    3'd6:
                    begin
                        port = PORT_STATUS;
                        val  = d.cmd;
                    end
                    default: rd = 1'b1;
                endcase
                b.access_valid = 1'b1;
                b.access_write = ~rd;
                b.access_port  = port;
                b.access_value = {8'h00, val};
            end
            SEQ_RD_DATA:
            begin
                b.access_valid = 1'b1;
                b.access_port  = PORT_DATA;
                b.access_wide  = 1'b1;
            end
            SEQ_DATA_RD:
            begin
                if (idx == 3'd0)
                begin
                    b.data_valid = 1'b1;
                    b.data_word  = d.value;
                end
                else
                begin
                    b.access_valid = 1'b1;
                    b.access_port  = PORT_DATA;
                    b.access_wide  = 1'b1;
                end
            end
            SEQ_DATA_DONE:
            begin
                if (idx == 3'd0)
                begin
                    b.data_valid = 1'b1;
                    b.data_word  = d.value;
                end
                else
                begin
                    b.done_res = 1'b1;
                    b.ok       = 1'b1;
                end
            end
            SEQ_WR_WORD:
            begin
                b.access_valid = 1'b1;
                b.access_write = 1'b1;
                b.access_port  = PORT_DATA;
                b.access_wide  = 1'b1;
                b.access_value = d.value;
            end
            SEQ_WR_LAST:
            begin
                b.access_valid = 1'b1;
                case (idx)
                    3'd0:
                    begin
                        b.access_write = 1'b1;
                        b.access_port  = PORT_DATA;
                        b.access_wide  = 1'b1;
                        b.access_value = d.value;
                    end
                    3'd1:
                    begin
                        b.access_write = 1'b1;
                        b.access_port  = PORT_STATUS;
                        b.access_value = {8'h00, OPC_CACHE_FLUSH};
                    end
                    default: b.access_port = PORT_STATUS;
                endcase
            end
            default: b.sector_count = d.sector_count;
        endcase
        return b;
    endfunction

endpackage

`default_nettype wire

[sv/ata_seq_core.sv]
// Input register, transaction state and per-item step logic of the sequencer.
`default_nettype none

module ata_seq_core (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic [1:0]         in_kind,
    input  wire logic [1:0]         in_op,
    input  wire logic [27:0]        in_lba,
    input  wire logic [15:0]        in_reply,
    input  wire logic [15:0]        in_wword,
    input  wire logic               can_load,
    output logic                    load,
    output ata_seq_pkg::desc_t      desc
);
    import ata_seq_pkg::*;

    logic        item_valid_reg;
    logic [1:0]  kind_reg;
    logic [1:0]  op_reg;
    logic [27:0] lba_reg;
    logic [15:0] reply_reg;
    logic [15:0] wword_reg;

    phase_t      phase_reg, phase_next;
    logic [20:0] poll_count_reg, poll_count_next;
    logic [8:0]  word_index_reg, word_index_next;
    logic [1:0]  delay_count_reg, delay_count_next;
    logic [27:0] held_lba_reg, held_lba_next;
    logic [1:0]  held_op_reg, held_op_next;
    logic        present_reg, present_next;
    logic [31:0] total_reg, total_next;

    logic [7:0]  status;
    logic        busy;
    logic        fault;
    logic        drq;
    logic        poll_out;
    logic        delay_end;
    logic [8:0]  word_inc;
    logic        words_done;
    logic        is_identify;
    logic        req_reject;

    assign load     = item_valid_reg & can_load;
    assign in_ready = ~item_valid_reg | load;

    assign status      = reply_reg[7:0];
    assign busy        = status[ST_BSY];
    assign fault       = status[ST_DF] | status[ST_ERR];
    assign drq         = status[ST_DRQ];
    assign poll_out    = poll_count_reg >= POLL_LIMIT;
    assign delay_end   = delay_count_reg == 2'd3;
    assign word_inc    = word_index_reg + 9'd1;
    assign words_done  = word_inc >= 9'(SECTOR_WORDS);
    assign is_identify = held_op_reg == OP_IDENTIFY;
    assign req_reject  = (op_reg == OP_INVALID) | ~present_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
        end
        else if (in_valid && in_ready)
        begin
            item_valid_reg <= 1'b1;
        end
        else if (load)
        begin
            item_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            kind_reg  <= in_kind;
            op_reg    <= in_op;
            lba_reg   <= in_lba;
            reply_reg <= in_reply;
            wword_reg <= in_wword;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_IDLE;
            poll_count_reg  <= '0;
            word_index_reg  <= '0;
            delay_count_reg <= '0;
            held_lba_reg    <= '0;
            held_op_reg     <= '0;
            present_reg     <= 1'b0;
            total_reg       <= '0;
        end
        else if (load)
        begin
            phase_reg       <= phase_next;
            poll_count_reg  <= poll_count_next;
            word_index_reg  <= word_index_next;
            delay_count_reg <= delay_count_next;
            held_lba_reg    <= held_lba_next;
            held_op_reg     <= held_op_next;
            present_reg     <= present_next;
            total_reg       <= total_next;
        end
    end

    // next state
    always_comb
    begin
        phase_next       = phase_reg;
        poll_count_next  = poll_count_reg;
        word_index_next  = word_index_reg;
        delay_count_next = delay_count_reg;
        held_lba_next    = held_lba_reg;
        held_op_next     = held_op_reg;
        present_next     = present_reg;
        total_next       = total_reg;
        unique case (kind_reg)
            KIND_REQUEST:
            begin
                if (phase_reg == PH_IDLE)
                begin
                    if (op_reg == OP_IDENTIFY)
                    begin
                        held_op_next     = OP_IDENTIFY;
                        phase_next       = PH_DELAY_A;
                        delay_count_next = 2'd0;
                    end
                    else if (!req_reject)
                    begin
                        held_op_next    = op_reg;
                        held_lba_next   = lba_reg;
                        phase_next      = PH_PRE_BSY;
                        poll_count_next = 21'd1;
                    end
                end
            end
            KIND_REPLY:
            begin
                unique case (phase_reg)
                    PH_DELAY_A, PH_DELAY_B:
                    begin
                        if (!delay_end)
                        begin
                            delay_count_next = delay_count_reg + 2'd1;
                        end
                        else
                        begin
                            delay_count_next = 2'd0;
                            if (phase_reg == PH_DELAY_A)
                            begin
                                phase_next = PH_CHECK1;
                            end
                            else if (is_identify)
                            begin
                                phase_next = PH_CHECK2;
                            end
                            else
                            begin
                                phase_next      = PH_BSY;
                                poll_count_next = 21'd1;
                            end
                        end
                    end
                    PH_CHECK1:
                    begin
                        if (status == 8'h00)
                        begin
                            phase_next = PH_IDLE;
                        end
                        else
                        begin
                            phase_next       = PH_DELAY_B;
                            delay_count_next = 2'd0;
                        end
                    end
                    PH_CHECK2:
                    begin
                        if (status == 8'h00)
                        begin
                            phase_next = PH_IDLE;
                        end
                        else
                        begin
                            phase_next      = PH_BSY;
                            poll_count_next = 21'd1;
                        end
                    end
                    PH_PRE_BSY, PH_BSY, PH_FLUSH:
                    begin
                        if (!busy)
                        begin
                            if (phase_reg == PH_PRE_BSY)
                            begin
                                phase_next       = PH_DELAY_B;
                                delay_count_next = 2'd0;
                            end
                            else if (phase_reg == PH_BSY)
                            begin
                                phase_next      = PH_DRQ;
                                poll_count_next = 21'd1;
                            end
                            else
                            begin
                                phase_next = PH_IDLE;
                            end
                        end
                        else if (poll_out)
                        begin
                            phase_next = PH_IDLE;
                        end
                        else
                        begin
                            poll_count_next = poll_count_reg + 21'd1;
                        end
                    end
                    PH_DRQ:
                    begin
                        if (fault)
                        begin
                            phase_next = PH_IDLE;
                        end
                        else if (drq)
                        begin
                            word_index_next = 9'd0;
                            phase_next = (held_op_reg == OP_WRITE) ? PH_WDATA : PH_RDATA;
                        end
                        else if (poll_out)
                        begin
                            phase_next = PH_IDLE;
                        end
                        else
                        begin
                            poll_count_next = poll_count_reg + 21'd1;
                        end
                    end
                    PH_RDATA:
                    begin
                        if (is_identify && word_index_reg == ID_WORD_CAP_LO)
                        begin
                            total_next[15:0] = reply_reg;
                        end
                        else if (is_identify && word_index_reg == ID_WORD_CAP_HI)
                        begin
                            total_next[31:16] = reply_reg;
                        end
                        word_index_next = word_inc;
                        if (words_done)
                        begin
                            phase_next = PH_IDLE;
                            if (is_identify)
                            begin
                                present_next = 1'b1;
                            end
                        end
                    end
                    default: phase_next = phase_reg;
                endcase
            end
            KIND_WDATA:
            begin
                if (phase_reg == PH_WDATA)
                begin
                    word_index_next = word_inc;
                    if (words_done)
                    begin
                        phase_next      = PH_FLUSH;
                        poll_count_next = 21'd1;
                    end
                end
            end
            default: phase_next = phase_reg;
        endcase
    end

    // result sequence for this item
    always_comb
    begin
        desc              = '0;
        desc.seq          = SEQ_NONE;
        desc.sector_count = total_next;
        desc.present      = present_next;
        unique case (kind_reg)
            KIND_REQUEST:
            begin
                if (phase_reg == PH_IDLE)
                begin
                    if (op_reg == OP_IDENTIFY)
                    begin
                        desc.seq = SEQ_ID_START;
                    end
                    else if (req_reject)
                    begin
                        desc.seq = SEQ_FINISH;
                    end
                    else
                    begin
                        desc.seq = SEQ_RD_STATUS;
                    end
                end
            end
            KIND_REPLY:
            begin
                unique case (phase_reg)
                    PH_DELAY_A, PH_DELAY_B: desc.seq = SEQ_RD_STATUS;
                    PH_CHECK1:
                    begin
                        if (status == 8'h00)
                        begin
                            desc.seq = SEQ_FINISH;
                        end
                        else
                        begin
                            desc.seq = SEQ_TASKFILE;
                            desc.cmd = OPC_IDENTIFY_DEV;
                        end
                    end
                    PH_CHECK2:
                    begin
                        desc.seq = (status == 8'h00) ? SEQ_FINISH : SEQ_RD_STATUS;
                    end
                    PH_PRE_BSY, PH_BSY, PH_FLUSH:
                    begin
                        if (!busy)
                        begin
                            if (phase_reg == PH_PRE_BSY)
                            begin
                                desc.seq   = SEQ_TASKFILE;
                                desc.lba   = held_lba_reg;
                                desc.count = 1'b1;
                                desc.cmd   = (held_op_reg == OP_WRITE) ? OPC_WRITE_SECT
                                                                       : OPC_READ_SECT;
                            end
                            else if (phase_reg == PH_BSY)
                            begin
                                desc.seq = SEQ_RD_STATUS;
                            end
                            else
                            begin
                                desc.seq = SEQ_FINISH;
                                desc.ok  = 1'b1;
                            end
                        end
                        else if (poll_out)
                        begin
                            desc.seq = SEQ_FINISH;
                            desc.ok  = phase_reg == PH_FLUSH;
                        end
                        else
                        begin
                            desc.seq = SEQ_RD_STATUS;
                        end
                    end
                    PH_DRQ:
                    begin
                        if (fault)
                        begin
                            desc.seq = SEQ_FINISH;
                        end
                        else if (drq)
                        begin
                            desc.seq = (held_op_reg == OP_WRITE) ? SEQ_NONE : SEQ_RD_DATA;
                        end
                        else if (poll_out)
                        begin
                            desc.seq = SEQ_FINISH;
                        end
                        else
                        begin
                            desc.seq = SEQ_RD_STATUS;
                        end
                    end
                    PH_RDATA:
                    begin
                        desc.value = reply_reg;
                        desc.ok    = 1'b1;
                        if (is_identify)
                        begin
                            desc.seq = words_done ? SEQ_FINISH : SEQ_RD_DATA;
                        end
                        else
                        begin
                            desc.seq = words_done ? SEQ_DATA_DONE : SEQ_DATA_RD;
                        end
                    end
                    default: desc.seq = SEQ_NONE;
                endcase
            end
            KIND_WDATA:
            begin
                if (phase_reg == PH_WDATA)
                begin
                    desc.value = wword_reg;
                    desc.seq   = words_done ? SEQ_WR_LAST : SEQ_WR_WORD;
                end
            end
            default: desc.seq = SEQ_NONE;
        endcase
    end

endmodule

`default_nettype wire

[sv/ata_seq_emit.sv]
// Result register and beat serializer: one result transfer per cycle while out_ready is high.
`default_nettype none

module ata_seq_emit (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                load,
    input  wire ata_seq_pkg::desc_t  desc,
    output logic                     can_load,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output ata_seq_pkg::beat_t       beat,
    output logic                     beat_last
);
    import ata_seq_pkg::*;

    desc_t      desc_reg;
    logic       busy_reg;
    logic [2:0] idx_reg;
    logic [3:0] len;
    logic       take;

    assign len       = seq_len(desc_reg.seq);
    assign beat      = make_beat(desc_reg, idx_reg);
    assign beat_last = ({1'b0, idx_reg} + 4'd1) == len;
    assign out_valid = busy_reg;
    assign take      = busy_reg & out_ready;
    assign can_load  = ~busy_reg | (take & beat_last);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            idx_reg  <= '0;
        end
        else if (load)
        begin
            busy_reg <= desc.seq != SEQ_NONE;
            idx_reg  <= '0;
        end
        else if (take)
        begin
            idx_reg <= idx_reg + 3'd1;
            if (beat_last)
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            desc_reg <= desc;
        end
    end

endmodule

`default_nettype wire

[sv/ata_pio_lba28_sequencer_unit.sv]
// Top level of the ATA PIO LBA28 host sequencer with stream ports.
`default_nettype none

// Polled ATA PIO host sequencer for the primary channel master drive. Requests,
// bus read replies and write data words enter on the slave stream (kind on
// s_tuser); every port access, sector word and completion leaves on the
// master stream, with tlast on the final transfer caused by an input item.
// An item is held in the input register, then its step is evaluated and its
// results (zero to eight transfers) are loaded into the result register and
// sent one per cycle while m_tready is high, the first offered in the cycle
// after the step. The input side takes a new item every cycle as long as the
// result register is empty or its final transfer leaves in that cycle; the
// serializer is the only limit on throughput. Items that cause no result
// still take a step. Every status poll gives up after 2000000 reads.
module ata_pio_lba28_sequencer_unit (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [63:0] s_tdata,   // op[1:0], lba[29:2], reply_value[45:30],
                                        // write_word[61:46], zero[63:62]
    input  wire logic [1:0]  s_tuser,   // kind[1:0]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [79:0]      m_tdata,   // access_write[0], access_port[10:1],
                                        // access_wide[11], access_value[27:12],
                                        // data_word[43:28], ok[44],
                                        // sector_count[76:45], present[77], zero[79:78]
    output logic [2:0]       m_tuser,   // access_valid[0], data_valid[1], done_res[2]
    output logic             m_tlast
);
    import ata_seq_pkg::*;

    desc_t desc;
    beat_t beat;
    logic  load;
    logic  can_load;

    ata_seq_core u_core (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .in_kind  (s_tuser),
        .in_op    (s_tdata[1:0]),
        .in_lba   (s_tdata[29:2]),
        .in_reply (s_tdata[45:30]),
        .in_wword (s_tdata[61:46]),
        .can_load (can_load),
        .load     (load),
        .desc     (desc)
    );

    ata_seq_emit u_emit (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (load),
        .desc      (desc),
        .can_load  (can_load),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .beat      (beat),
        .beat_last (m_tlast)
    );

    assign m_tdata = {2'b00, beat.present, beat.sector_count, beat.ok, beat.data_word,
                      beat.access_value, beat.access_wide, beat.access_port,
                      beat.access_write};
    assign m_tuser = {beat.done_res, beat.data_valid, beat.access_valid};

endmodule

`default_nettype wire

[tb/sv/ata_seq_bus_monitor.sv]
// Bus monitor for the ATA PIO LBA28 sequencer: predicts each output transfer and checks it.
module ata_seq_bus_monitor (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [63:0] s_tdata,
    input  logic [1:0]  s_tuser,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [79:0] m_tdata,
    input  logic [2:0]  m_tuser,
    input  logic        m_tlast,
    output int          pending_accesses,
    output int          mismatch_count
);
    import ata_seq_pkg::*;

    typedef struct packed {
        logic        access_valid;
        logic        access_write;
        logic [9:0]  access_port;
        logic        access_wide;
        logic [15:0] access_value;
        logic        data_valid;
        logic [15:0] data_word;
        logic        done_res;
        logic        ok;
        logic        last;
        logic [31:0] sector_count;
        logic        present;
    } host_xfer_t;

    host_xfer_t  expected_xfers[$];
    host_xfer_t  step_xfers[$];

    phase_t      host_phase;
    logic [20:0] poll_reads;
    logic [8:0]  word_pos;
    logic [1:0]  settle_reads;
    logic [27:0] cmd_lba;
    logic [1:0]  cmd_op;
    logic        drive_found;
    logic [31:0] drive_sectors;

    task automatic emit(input logic av, input logic wr, input logic [9:0] port,
                        input logic wide, input logic [15:0] val, input logic dv,
                        input logic [15:0] dw, input logic done, input logic okv);
        host_xfer_t x;
        x              = '0;
        x.access_valid = av;
        x.access_write = wr;
        x.access_port  = port;
        x.access_wide  = wide;
        x.access_value = val;
        x.data_valid   = dv;
        x.data_word    = dw;
        x.done_res     = done;
        x.ok           = okv;
        if (step_xfers.size() < 9)
            step_xfers.push_back(x);
    endtask

    task automatic emit_byte(input logic [9:0] port, input logic [7:0] val);
        emit(1'b1, 1'b1, port, 1'b0, {8'h00, val}, 1'b0, 16'h0000, 1'b0, 1'b0);
    endtask

    task automatic emit_status_read();
        emit(1'b1, 1'b0, PORT_STATUS, 1'b0, 16'h0000, 1'b0, 16'h0000, 1'b0, 1'b0);
    endtask

    task automatic emit_data_read();
        emit(1'b1, 1'b0, PORT_DATA, 1'b1, 16'h0000, 1'b0, 16'h0000, 1'b0, 1'b0);
    endtask

    task automatic finish_request(input logic okv);
        emit(1'b0, 1'b0, 10'd0, 1'b0, 16'h0000, 1'b0, 16'h0000, 1'b1, okv);
        host_phase = PH_IDLE;
    endtask

    task automatic begin_poll(input phase_t next);
        host_phase = next;
        poll_reads = 21'd1;
        emit_status_read();
    endtask

    task automatic begin_settle(input phase_t next);
        host_phase   = next;
        settle_reads = 2'd0;
        emit_status_read();
    endtask

    task automatic load_taskfile(input logic [27:0] lba, input logic count, input logic [7:0] cmd);
        emit_byte(PORT_DRIVE, DRV_LBA | {4'h0, lba[27:24]});
        emit_byte(PORT_FEATURE, 8'h00);
        emit_byte(PORT_COUNT, {7'd0, count});
        emit_byte(PORT_LBA_LO, lba[7:0]);
        emit_byte(PORT_LBA_MID, lba[15:8]);
        emit_byte(PORT_LBA_HI, lba[23:16]);
        emit_byte(PORT_STATUS, cmd);
        begin_settle(PH_DELAY_B);
    endtask

    task automatic poll_retry(output logic give_up);
        give_up = (poll_reads >= POLL_LIMIT);
        if (!give_up)
        begin
            poll_reads = poll_reads + 21'd1;
            emit_status_read();
        end
    endtask

    task automatic take_reply(input logic [15:0] v);
        logic [7:0] st;
        logic       give_up;
        st = v[7:0];
        case (host_phase)
            PH_DELAY_A, PH_DELAY_B:
            begin
                if (settle_reads < 2'd3)
                begin
                    settle_reads = settle_reads + 2'd1;
                    emit_status_read();
                end
                else
                begin
                    settle_reads = 2'd0;
                    if (host_phase == PH_DELAY_A)
                    begin
                        host_phase = PH_CHECK1;
                        emit_status_read();
                    end
                    else if (cmd_op == OP_IDENTIFY)
                    begin
                        host_phase = PH_CHECK2;
                        emit_status_read();
                    end
                    else
                        begin_poll(PH_BSY);
                end
            end
            PH_CHECK1:
            begin
                if (st == 8'h00)
                    finish_request(1'b0);
                else
                    load_taskfile(28'd0, 1'b0, OPC_IDENTIFY_DEV);
            end
            PH_CHECK2:
            begin
                if (st == 8'h00)
                    finish_request(1'b0);
                else
                    begin_poll(PH_BSY);
            end
            PH_PRE_BSY:
            begin
                if (!st[ST_BSY])
                    load_taskfile(cmd_lba, 1'b1,
                                  (cmd_op == OP_WRITE) ? OPC_WRITE_SECT : OPC_READ_SECT);
                else
                begin
                    poll_retry(give_up);
                    if (give_up)
                        finish_request(1'b0);
                end
            end
            PH_BSY:
            begin
                if (!st[ST_BSY])
                    begin_poll(PH_DRQ);
                else
                begin
                    poll_retry(give_up);
                    if (give_up)
                        finish_request(1'b0);
                end
            end
            PH_DRQ:
            begin
                if (st[ST_DF] || st[ST_ERR])
                    finish_request(1'b0);
                else if (st[ST_DRQ])
                begin
                    word_pos = 9'd0;
                    if (cmd_op == OP_WRITE)
                        host_phase = PH_WDATA;
                    else
                    begin
                        host_phase = PH_RDATA;
                        emit_data_read();
                    end
                end
                else
                begin
                    poll_retry(give_up);
                    if (give_up)
                        finish_request(1'b0);
                end
            end
            PH_RDATA:
            begin
                if (cmd_op == OP_IDENTIFY)
                begin
                    if (word_pos == ID_WORD_CAP_LO)
                        drive_sectors[15:0] = v;
                    else if (word_pos == ID_WORD_CAP_HI)
                        drive_sectors[31:16] = v;
                end
                else
                    emit(1'b0, 1'b0, 10'd0, 1'b0, 16'h0000, 1'b1, v, 1'b0, 1'b0);
                word_pos = word_pos + 9'd1;
                if (word_pos >= SECTOR_WORDS)
                begin
                    if (cmd_op == OP_IDENTIFY)
                        drive_found = 1'b1;
                    finish_request(1'b1);
                end
                else
                    emit_data_read();
            end
            PH_FLUSH:
            begin
                if (!st[ST_BSY])
                    finish_request(1'b1);
                else
                begin
                    poll_retry(give_up);
                    if (give_up)
                        finish_request(1'b1);
                end
            end
            default:
            begin
            end
        endcase
    endtask

    task automatic predict_port_activity(input logic [1:0] kind, input logic [1:0] op,
                                         input logic [27:0] lba, input logic [15:0] reply,
                                         input logic [15:0] wword);
        host_xfer_t x;
        step_xfers.delete();
        case (kind)
            KIND_REQUEST:
            begin
                if (host_phase == PH_IDLE)
                begin
                    if (op == OP_IDENTIFY)
                    begin
                        cmd_op = OP_IDENTIFY;
                        emit_byte(PORT_DRIVE, DRV_SELECT);
                        begin_settle(PH_DELAY_A);
                    end
                    else if (op == OP_INVALID || !drive_found)
                        finish_request(1'b0);
                    else
                    begin
                        cmd_op  = op;
                        cmd_lba = lba;
                        begin_poll(PH_PRE_BSY);
                    end
                end
            end
            KIND_REPLY:
                take_reply(reply);
            KIND_WDATA:
            begin
                if (host_phase == PH_WDATA)
                begin
                    emit(1'b1, 1'b1, PORT_DATA, 1'b1, wword, 1'b0, 16'h0000, 1'b0, 1'b0);
                    word_pos = word_pos + 9'd1;
                    if (word_pos >= SECTOR_WORDS)
                    begin
                        emit_byte(PORT_STATUS, OPC_CACHE_FLUSH);
                        begin_poll(PH_FLUSH);
                    end
                end
            end
            default:
            begin
            end
        endcase
        for (int i = 0; i < step_xfers.size(); i++)
        begin
            x              = step_xfers[i];
            x.last         = (i == step_xfers.size() - 1);
            x.sector_count = drive_sectors;
            x.present      = drive_found;
            expected_xfers.push_back(x);
        end
    endtask

    task automatic check_field(input string name, input logic [31:0] want_v,
                               input logic [31:0] got_v);
        if (want_v !== got_v)
        begin
            $error("%s expected 0x%0h actual 0x%0h", name, want_v, got_v);
            mismatch_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        host_xfer_t want;
        if (!rst_n)
        begin
            host_phase    = PH_IDLE;
            poll_reads    = '0;
            word_pos      = '0;
            settle_reads  = '0;
            cmd_lba       = '0;
            cmd_op        = '0;
            drive_found   = 1'b0;
            drive_sectors = '0;
            expected_xfers.delete();
            mismatch_count = 0;
            pending_accesses <= 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
                predict_port_activity(s_tuser, s_tdata[1:0], s_tdata[29:2], s_tdata[45:30],
                                      s_tdata[61:46]);
            if (m_tvalid && m_tready)
            begin
                if (expected_xfers.size() == 0)
                begin
                    $error("output transfer arrived with nothing expected");
                    mismatch_count++;
                end
                else
                begin
                    want = expected_xfers.pop_front();
                    check_field("access_valid", 32'(want.access_valid), 32'(m_tuser[0]));
                    check_field("access_write", 32'(want.access_write), 32'(m_tdata[0]));
                    check_field("access_port", 32'(want.access_port), 32'(m_tdata[10:1]));
                    check_field("access_wide", 32'(want.access_wide), 32'(m_tdata[11]));
                    check_field("access_value", 32'(want.access_value), 32'(m_tdata[27:12]));
                    check_field("data_valid", 32'(want.data_valid), 32'(m_tuser[1]));
                    check_field("data_word", 32'(want.data_word), 32'(m_tdata[43:28]));
                    check_field("done_res", 32'(want.done_res), 32'(m_tuser[2]));
                    check_field("ok", 32'(want.ok), 32'(m_tdata[44]));
                    check_field("last", 32'(want.last), 32'(m_tlast));
                    check_field("sector_count", want.sector_count, m_tdata[76:45]);
                    check_field("present", 32'(want.present), 32'(m_tdata[77]));
                end
            end
            pending_accesses <= expected_xfers.size();
        end
    end

endmodule

[tb/sv/tb_ata_pio_lba28_sequencer_unit.sv]
// Testbench top for the ATA PIO LBA28 sequencer: clock, reset, stimulus and verdict.
module tb_ata_pio_lba28_sequencer_unit;
    import ata_seq_pkg::*;

    localparam int          RANDOM_COMMANDS = 4;
    localparam int          CAPTURE_WORDS   = 64;
    localparam int          LONG_HOLD       = 300;
    localparam int          DRAIN_CYCLES    = 16;
    localparam longint      RUN_LIMIT       = 64'd2_000_000;
    localparam logic [1:0]  KIND_UNUSED     = 2'd3;
    localparam logic [7:0]  MASK_BSY        = 8'd1 << ST_BSY;
    localparam logic [7:0]  MASK_DF         = 8'd1 << ST_DF;
    localparam logic [7:0]  MASK_DRQ        = 8'd1 << ST_DRQ;
    localparam logic [7:0]  MASK_ERR        = 8'd1 << ST_ERR;

    typedef enum logic [1:0] {HOST_IDLE, HOST_BUSY, HOST_WDATA} host_state_t;
    typedef enum logic [1:0] {FAULT_NONE, FAULT_CHECK1, FAULT_CHECK2, FAULT_DRQ} fault_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [63:0] s_tdata;
    logic [1:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [79:0] m_tdata;
    logic [2:0]  m_tuser;
    logic        m_tlast;
    int          pending_accesses;
    int          mismatch_count;

    logic        calm;
    logic        hold_req;
    logic        have_drive;
    host_state_t host_state;
    int          n_requests;
    int          n_replies;
    int          n_words;
    int          n_noise;
    int          n_identify;
    int          n_read;
    int          n_write;

    ata_pio_lba28_sequencer_unit dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    ata_seq_bus_monitor bus_monitor (
        .clk              (clk),
        .rst_n            (rst_n),
        .s_tvalid         (s_tvalid),
        .s_tready         (s_tready),
        .s_tdata          (s_tdata),
        .s_tuser          (s_tuser),
        .m_tvalid         (m_tvalid),
        .m_tready         (m_tready),
        .m_tdata          (m_tdata),
        .m_tuser          (m_tuser),
        .m_tlast          (m_tlast),
        .pending_accesses (pending_accesses),
        .mismatch_count   (mismatch_count)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    initial
    begin
        #(RUN_LIMIT);
        $display("[ata_pio_lba28_sequencer_unit] ERROR");
        $finish;
    end

    initial
    begin
        m_tready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                m_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
                hold_req = 1'b0;
                m_tready <= 1'b1;
            end
            else if (!calm && $urandom_range(0, 9) == 0)
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 16)) @(posedge clk);
                m_tready <= 1'b1;
            end
            else
                m_tready <= 1'b1;
        end
    end

    function automatic logic [15:0] status_word(input logic [7:0] set_mask,
                                                input logic [7:0] clear_mask);
        logic [15:0] v;
        v      = 16'($urandom());
        v[7:0] = (v[7:0] | set_mask) & ~clear_mask;
        return v;
    endfunction

    task automatic push_item(input logic [1:0] kind, input logic [1:0] op, input logic [27:0] lba,
                             input logic [15:0] reply, input logic [15:0] wword);
        if (!calm && $urandom_range(0, 3) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {2'b00, wword, reply, lba, op};
        do
        begin
            @(posedge clk);
        end
        while (!s_tready);
    endtask

    task automatic push_random(input logic [1:0] kind);
        push_item(kind, 2'($urandom()), 28'($urandom()), 16'($urandom()), 16'($urandom()));
    endtask

    task automatic maybe_noise();
        int pick;
        if ($urandom_range(0, 24) == 0)
        begin
            pick = int'($urandom_range(0, 2));
            n_noise++;
            if (pick == 1 && host_state != HOST_WDATA)
                push_random(KIND_WDATA);
            else if (pick == 2 && host_state != HOST_IDLE)
                push_random(KIND_REQUEST);
            else if (pick == 2)
                push_random(KIND_REPLY);
            else
                push_random(KIND_UNUSED);
        end
    endtask

    task automatic send_reply(input logic [15:0] v);
        maybe_noise();
        push_item(KIND_REPLY, 2'($urandom()), 28'($urandom()), v, 16'($urandom()));
        n_replies++;
    endtask

    task automatic send_word(input logic [15:0] w);
        maybe_noise();
        push_item(KIND_WDATA, 2'($urandom()), 28'($urandom()), 16'($urandom()), w);
        n_words++;
    endtask

    task automatic send_request(input logic [1:0] op, input logic [27:0] lba);
        push_item(KIND_REQUEST, op, lba, 16'($urandom()), 16'($urandom()));
        n_requests++;
    endtask

    task automatic poll_through_busy();
        int spins;
        spins = ($urandom_range(0, 9) == 0) ? int'($urandom_range(4, 20))
                                             : int'($urandom_range(0, 2));
        repeat (spins) send_reply(status_word(MASK_BSY, 8'h00));
        send_reply(status_word(8'h00, MASK_BSY));
    endtask

    task automatic wait_drq(input logic fault);
        int spins;
        spins = ($urandom_range(0, 9) == 0) ? int'($urandom_range(4, 20))
                                             : int'($urandom_range(0, 2));
        repeat (spins) send_reply(status_word(8'h00, MASK_ERR | MASK_DF | MASK_DRQ));
        if (fault)
            send_reply(status_word($urandom_range(0, 1) ? MASK_ERR : MASK_DF, 8'h00));
        else
            send_reply(status_word(MASK_DRQ, MASK_ERR | MASK_DF));
    endtask

    task automatic run_identify(input fault_t fault, input logic long_stall, input int words);
        n_identify++;
        send_request(OP_IDENTIFY, 28'($urandom()));
        host_state = HOST_BUSY;
        repeat (4) send_reply(16'($urandom()));
        if (fault == FAULT_CHECK1)
            send_reply(status_word(8'h00, 8'hFF));
        else
        begin
            send_reply(status_word(8'd1 << $urandom_range(0, 7), 8'h00));
            repeat (4) send_reply(16'($urandom()));
            if (fault == FAULT_CHECK2)
                send_reply(status_word(8'h00, 8'hFF));
            else
            begin
                send_reply(status_word(8'd1 << $urandom_range(0, 7), 8'h00));
                if (long_stall)
                    hold_req = 1'b1;
                poll_through_busy();
                wait_drq(fault == FAULT_DRQ);
                if (fault != FAULT_DRQ)
                begin
                    repeat (words) send_reply(16'($urandom()));
                    if (words >= SECTOR_WORDS)
                        have_drive = 1'b1;
                end
            end
        end
        host_state = HOST_IDLE;
    endtask

    task automatic run_transfer(input logic [1:0] op, input logic [27:0] lba, input logic fault);
        if (op == OP_READ)
            n_read++;
        else if (op == OP_WRITE)
            n_write++;
        send_request(op, lba);
        if (have_drive && (op == OP_READ || op == OP_WRITE))
        begin
            host_state = HOST_BUSY;
            poll_through_busy();
            repeat (4) send_reply(16'($urandom()));
            poll_through_busy();
            wait_drq(fault);
            if (!fault && op == OP_WRITE)
            begin
                host_state = HOST_WDATA;
                repeat (SECTOR_WORDS) send_word(16'($urandom()));
                host_state = HOST_BUSY;
                poll_through_busy();
            end
            else if (!fault)
                repeat (SECTOR_WORDS) send_reply(16'($urandom()));
            host_state = HOST_IDLE;
        end
    endtask

    initial
    begin
        int pick;
        calm       = 1'b0;
        hold_req   = 1'b0;
        have_drive = 1'b0;
        host_state = HOST_IDLE;
        n_requests = 0;
        n_replies  = 0;
        n_words    = 0;
        n_noise    = 0;
        n_identify = 0;
        n_read     = 0;
        n_write    = 0;
        rst_n    <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tuser  <= KIND_REQUEST;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        push_item(KIND_REPLY, OP_INVALID, 28'hFFFFFFF, 16'hFFFF, 16'h0000);
        push_item(KIND_WDATA, OP_IDENTIFY, 28'h0000000, 16'h0000, 16'hFFFF);
        push_item(KIND_UNUSED, OP_WRITE, 28'hFFFFFFF, 16'hFFFF, 16'hFFFF);
        run_transfer(OP_READ, 28'h0000000, 1'b0);
        run_transfer(OP_WRITE, 28'hFFFFFFF, 1'b0);
        run_transfer(OP_INVALID, 28'hFFFFFFF, 1'b0);
        run_identify(FAULT_CHECK1, 1'b0, 0);
        run_identify(FAULT_CHECK2, 1'b0, 0);
        run_identify(FAULT_DRQ, 1'b1, 0);

        s_tvalid <= 1'b0;
        repeat (2) @(posedge clk);
        while (pending_accesses != 0)
            @(posedge clk);

        for (int i = 0; i < RANDOM_COMMANDS; i++)
        begin
            maybe_noise();
            pick = int'($urandom_range(0, 3));
            if (pick == 0)
                run_identify(fault_t'(2'($urandom_range(1, 3))), 1'b0, 0);
            else if (pick == 1)
                run_transfer(OP_READ, 28'($urandom()), 1'b0);
            else if (pick == 2)
                run_transfer(OP_WRITE, 28'($urandom()), 1'b0);
            else
                run_transfer(OP_INVALID, 28'($urandom()), 1'b0);
        end

        calm = 1'b1;
        run_identify(FAULT_NONE, 1'b0, CAPTURE_WORDS);

        s_tvalid <= 1'b0;
        repeat (2) @(posedge clk);
        while (pending_accesses != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Run covered %0d requests (%0d identify, %0d read, %0d write), %0d replies,",
                 n_requests, n_identify, n_read, n_write, n_replies);
        $display("%0d write words, %0d stray items, a %0d-cycle output stall, %0d id words.",
                 n_words, n_noise, LONG_HOLD, CAPTURE_WORDS);
        if (mismatch_count == 0 && pending_accesses == 0)
            $display("[ata_pio_lba28_sequencer_unit] OK");
        else
            $display("[ata_pio_lba28_sequencer_unit] ERROR");
        $finish;
    end

endmodule
